// File: rtl/jad_pkg.sv
`timescale 1ns / 1ps

package jad_pkg;

    // widths fixed by the register map and the result field
    localparam int REG_BITS        = 16;
    localparam int LEVEL_BITS      = 8;
    localparam int CNT_BITS        = 8;
    localparam int QUO_BITS        = 7;
    localparam int QCNT_BITS       = 3;
    localparam int CFG_IDX_BITS    = 3;
    localparam int SAMPLE_BITS_DEF = 16;

    // register reset values
    localparam logic [REG_BITS-1:0]   DEAD_LOW_RST   = 16'd30000;
    localparam logic [REG_BITS-1:0]   DEAD_HIGH_RST  = 16'd35000;
    localparam logic [REG_BITS-1:0]   LEFT_FULL_RST  = 16'd2000;
    localparam logic [REG_BITS-1:0]   RIGHT_FULL_RST = 16'd63000;
    localparam logic [LEVEL_BITS-1:0] POWER_RST      = 8'd16;
    localparam logic [CNT_BITS-1:0]   THRESH_RST     = 8'd1;

    // debounce limits
    localparam logic [CNT_BITS-1:0]   COUNT_MAX  = 8'd255;
    localparam logic [CNT_BITS-1:0]   THRESH_CAP = 8'd254;
    localparam logic [LEVEL_BITS-1:0] POWER_MIN  = 8'd2;

    typedef logic signed [LEVEL_BITS-1:0] t_level;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEAD_LOW   = 3'd0,
        CFG_DEAD_HIGH  = 3'd1,
        CFG_LEFT_FULL  = 3'd2,
        CFG_RIGHT_FULL = 3'd3,
        CFG_POWER      = 3'd4,
        CFG_THRESH     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPDATE
    } t_state;

endpackage

// File: rtl/jad_if.sv
`timescale 1ns / 1ps

// raw sample channel
interface jad_sample_if #(
    parameter int SAMPLE_BITS = jad_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// power level result channel
interface jad_level_if;
    import jad_pkg::*;

    logic   valid;
    logic   ready;
    t_level level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// register write channel
interface jad_cfg_if;
    import jad_pkg::*;

    logic                valid;
    logic                ready;
    t_cfg_idx            index;
    logic [REG_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/joystick_axis_power_debounce_unit.sv
`timescale 1ns / 1ps

// Joystick axis to signed power level, with repeat debounce.
// i_sample_ch carries one raw axis sample per transfer. o_level_ch carries a
// signed power level, sent only once the same level has come up r_thresh+2
// times in a row (255 acts as 254); most samples give no output transfer.
// i_cfg_ch writes the six setup registers by index; it is always ready and
// should only be used while no sample is in flight.
// A sample in the dead band or a full-power zone goes from its transfer
// straight to the debounce update state and then to the output register. A
// sample on a linear slope passes the multiply state, the divide state of a
// shared restoring divider (one quotient bit per cycle, the quotient never
// exceeds 7 bits) and the debounce update state. The next sample is taken in
// the cycle after the update; no new sample is taken while one is in flight.
// The output register holds a finished level while the receiver stalls; a
// new sample can still be taken, and its update waits only if it has to
// emit and the previous level has not been taken yet.
// Reset loads the default register values, clears the last level and the
// repeat count to zero and empties the output register.
module joystick_axis_power_debounce_unit #(
    parameter int SAMPLE_BITS = jad_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jad_sample_if.sink  i_sample_ch,
    jad_cfg_if.sink     i_cfg_ch,
    jad_level_if.source o_level_ch
);
    import jad_pkg::*;

    // registers keep full width, written values are masked to the sample width
    localparam int RW = REG_BITS;
    localparam int MW = (SAMPLE_BITS < REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int CW = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int PW = RW + QUO_BITS;

    // setup registers
    logic [RW-1:0]         r_dead_low, r_dead_high, r_left_full, r_right_full;
    logic [LEVEL_BITS-1:0] r_power;
    logic [CNT_BITS-1:0]   r_thresh;

    // control state
    t_state                r_state, n_state;
    t_level                r_last_level, n_last_level;
    logic [CNT_BITS-1:0]   r_rep_cnt, n_rep_cnt;
    logic                  r_out_valid, n_out_valid;

    // datapath
    t_level                r_out_level, n_out_level;
    t_level                r_fix_level, n_fix_level;
    logic                  r_use_div, n_use_div;
    logic                  r_left, n_left;
    logic [RW-1:0]         r_norm, n_norm;
    logic [RW-1:0]         r_span, n_span;
    logic [QUO_BITS-1:0]   r_steps, n_steps;
    logic [PW-1:0]         r_rem, n_rem;
    logic [QUO_BITS-1:0]   r_quo, n_quo;
    logic [QCNT_BITS-1:0]  r_qcnt, n_qcnt;

    // classification helpers
    logic [CW-1:0]          s, dl, dh, lf, rf;
    logic [LEVEL_BITS-1:0]  power_eff;
    logic [QUO_BITS-1:0]    top;
    logic [RW-1:0]          right_span;

    // shared divider step
    logic [PW-1:0]          div_shift;
    logic [PW:0]            div_trial;

    // debounce helpers
    t_level                 new_level;
    logic [CNT_BITS-1:0]    thr_eff;
    logic                   emit;

    assign s  = CW'(i_sample_ch.sample);
    assign dl = CW'(r_dead_low);
    assign dh = CW'(r_dead_high);
    assign lf = CW'(r_left_full);
    assign rf = CW'(r_right_full);

    assign power_eff  = (r_power < POWER_MIN) ? POWER_MIN : r_power;
    assign top        = power_eff[LEVEL_BITS-1:1];
    assign right_span = r_right_full - r_dead_high;

    assign div_shift = PW'(r_span) << r_qcnt;
    assign div_trial = {1'b0, r_rem} - {1'b0, div_shift};

    assign thr_eff = (r_thresh == COUNT_MAX) ? THRESH_CAP : r_thresh;

    // level from the slope quotient or the fixed zone value
    always_comb begin
        if (r_use_div) begin
            if (r_left) begin
                new_level = t_level'({1'b0, r_quo} - {1'b0, r_steps});
            end else begin
                new_level = t_level'({1'b0, r_quo} + 8'd1);
            end
        end else begin
            new_level = r_fix_level;
        end
    end

    assign emit = (new_level == r_last_level) && (r_rep_cnt == thr_eff);

    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign i_cfg_ch.ready    = 1'b1;
    assign o_level_ch.valid  = r_out_valid;
    assign o_level_ch.level  = r_out_level;

    // sequencer: next state and datapath loads
    always_comb begin
        n_state      = r_state;
        n_last_level = r_last_level;
        n_rep_cnt    = r_rep_cnt;
        n_out_valid  = r_out_valid && !o_level_ch.ready;
        n_out_level  = r_out_level;
        n_fix_level  = r_fix_level;
        n_use_div    = r_use_div;
        n_left       = r_left;
        n_norm       = r_norm;
        n_span       = r_span;
        n_steps      = r_steps;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_qcnt       = r_qcnt;

        case (r_state)
            S_IDLE: begin
                if (i_sample_ch.valid) begin
                    n_steps     = top - 7'd1;
                    n_use_div   = 1'b0;
                    n_left      = 1'b0;
                    n_fix_level = '0;
                    n_norm      = '0;
                    n_span      = '0;
                    if (s == dl || (s > dl && s < dh)) begin
                        n_fix_level = '0;
                    end else if (s < dl) begin
                        if (s < lf) begin
                            n_fix_level = t_level'(8'd0 - {1'b0, top});
                        end else begin
                            n_use_div = 1'b1;
                            n_left    = 1'b1;
                            n_norm    = RW'(s - lf);
                            n_span    = r_dead_low - r_left_full;
                        end
                    end else begin
                        if (s > rf || right_span == '0) begin
                            n_fix_level = t_level'({1'b0, top});
                        end else begin
                            n_use_div = 1'b1;
                            n_norm    = RW'(s - dh);
                            n_span    = right_span;
                        end
                    end
                    n_state = n_use_div ? S_MUL : S_UPDATE;
                end
            end
            S_MUL: begin
                n_rem   = PW'(r_steps) * PW'(r_norm);
                n_quo   = '0;
                n_qcnt  = QCNT_BITS'(QUO_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!div_trial[PW]) begin
                    n_rem         = div_trial[PW-1:0];
                    n_quo[r_qcnt] = 1'b1;
                end
                if (r_qcnt == '0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_qcnt = r_qcnt - 3'd1;
                end
            end
            S_UPDATE: begin
                if (!(emit && r_out_valid && !o_level_ch.ready)) begin
                    if (new_level == r_last_level) begin
                        if (r_rep_cnt != COUNT_MAX) begin
                            n_rep_cnt = r_rep_cnt + 8'd1;
                        end
                    end else begin
                        n_rep_cnt = '0;
                    end
                    n_last_level = new_level;
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_out_level = new_level;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and setup register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_level <= '0;
            r_rep_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_dead_low   <= DEAD_LOW_RST[RW-1:0];
            r_dead_high  <= DEAD_HIGH_RST[RW-1:0];
            r_left_full  <= LEFT_FULL_RST[RW-1:0];
            r_right_full <= RIGHT_FULL_RST[RW-1:0];
            r_power      <= POWER_RST;
            r_thresh     <= THRESH_RST;
        end else begin
            r_state      <= n_state;
            r_last_level <= n_last_level;
            r_rep_cnt    <= n_rep_cnt;
            r_out_valid  <= n_out_valid;
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.index)
                    CFG_DEAD_LOW:   r_dead_low   <= RW'(i_cfg_ch.data[MW-1:0]);
                    CFG_DEAD_HIGH:  r_dead_high  <= RW'(i_cfg_ch.data[MW-1:0]);
                    CFG_LEFT_FULL:  r_left_full  <= RW'(i_cfg_ch.data[MW-1:0]);
                    CFG_RIGHT_FULL: r_right_full <= RW'(i_cfg_ch.data[MW-1:0]);
                    CFG_POWER:      r_power      <= i_cfg_ch.data[LEVEL_BITS-1:0];
                    CFG_THRESH:     r_thresh     <= i_cfg_ch.data[CNT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out_level <= n_out_level;
        r_fix_level <= n_fix_level;
        r_use_div   <= n_use_div;
        r_left      <= n_left;
        r_norm      <= n_norm;
        r_span      <= n_span;
        r_steps     <= n_steps;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_qcnt      <= n_qcnt;
    end

`ifndef NO_ASSERTIONS
    // slope quotient never passes the step count
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_use_div) |-> (r_quo <= r_steps))
        else $error("slope quotient exceeds step count");

    // divider leaves a remainder below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_use_div) |-> (r_rem < PW'(r_span)))
        else $error("divider remainder not below span");

    // output register is only loaded by a debounce update
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPDATE))
        else $error("output loaded outside update");
`endif

endmodule
